[rtl/core/id_bitmap_allocator_assert.svh]
// assertion macros for the id bitmap allocator
`ifndef ID_BITMAP_ALLOCATOR_ASSERT_SVH
`define ID_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define IBMA_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ibma check failed");

// next-cycle implication
`define IBMA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ibma check failed");

`endif

[rtl/core/ibma_pkg.sv]
`timescale 1ns / 1ps

package ibma_pkg;

   typedef enum logic [1:0] {
      OP_FIND    = 2'd0,
      OP_MARK    = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_EVAL  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   typedef struct packed {
      logic       found;
      logic [9:0] free_id;
   } hit_type;

   localparam int BYTE_POS_W = 10;
   localparam logic [7:0] BYTE_FULL = 8'hFF;

endpackage

[rtl/core/ibma_word_scan.sv]
`timescale 1ns / 1ps

module ibma_word_scan #(
   parameter int WORD_BITS = 64
) (
   input  logic [WORD_BITS-1:0]            word,
   input  logic [ibma_pkg::BYTE_POS_W-1:0] base,
   input  logic [6:0]                      start_byte,
   input  logic [7:0]                      limit,
   output ibma_pkg::hit_type               hit
);
   import ibma_pkg::*;

   localparam int BPW     = WORD_BITS / 8;
   localparam int WB_LOG2 = $clog2(WORD_BITS);

   logic [BPW-1:0]       byte_ok;
   logic [WORD_BITS-1:0] free_bits;
   logic [WB_LOG2-1:0]   pos;
   logic [BYTE_POS_W-1:0] g;

   // a byte counts only inside [start_byte, limit)
   always_comb begin
      g = '0;
      for (int k = 0; k < BPW; k++) begin
         g = base + BYTE_POS_W'(k);
         byte_ok[k] = (g >= {3'b000, start_byte}) && (g < {2'b00, limit});
      end
   end

   // lowest clear bit of an eligible byte is the first non-full byte's lowest zero
   always_comb begin
      pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         free_bits[b] = ~word[b] & byte_ok[b / 8];
         if (free_bits[b]) begin
            pos = WB_LOG2'(b);
         end
      end
   end

   always_comb begin
      hit.found   = |free_bits;
      hit.free_id = hit.found ? ({base[6:0], 3'b000} + 10'(pos)) : 10'd0;
   end

endmodule

[rtl/core/id_bitmap_allocator.sv]
`timescale 1ns / 1ps
// flow: an accepted beat evaluates the bitmap words it reads in ST_EVAL, then ST_DONE loads its
// result beat once the output is free; words read: 1 for mark or release, up to ID_COUNT/WORD_BITS for a find,
// 0 for an empty search, an id out of range or an unused opcode, which go straight to ST_DONE
// throughput: one item at a time, the next beat is taken the cycle after the result loads
// reset: synchronous; afterwards a clearing pass over all ID_COUNT/WORD_BITS words zeroes the
// bitmap, req_tready stays low during it while csr writes are taken as usual

module id_bitmap_allocator #(
   parameter int ID_COUNT  = 1024,
   parameter int WORD_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // opcode[1:0], start_byte[8:2], id[18:9]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // found[0], free_id[10:1], byte_after[18:11]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // bytes_in_use
);
   import ibma_pkg::*;

   `include "id_bitmap_allocator_assert.svh"

   localparam int WORD_COUNT  = ID_COUNT / WORD_BITS;
   localparam int TOTAL_BYTES = ID_COUNT / 8;
   localparam int BPW         = WORD_BITS / 8;
   localparam int BPW_LOG2    = $clog2(BPW);
   localparam int WB_LOG2     = $clog2(WORD_BITS);
   localparam int AW          = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

   // bitmap memory
   logic [WORD_BITS-1:0] usage_mem [WORD_COUNT];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 mem_re;
   logic                 mem_we;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   state_type             state_ff, state_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [BYTE_POS_W-1:0] base_ff, base_in;
   logic [6:0]            start_ff, start_in;
   op_type                op_ff, op_in;
   logic [9:0]            id_ff, id_in;
   logic                  res_found_ff, res_found_in;
   logic [9:0]            res_id_ff, res_id_in;
   logic [7:0]            res_byte_ff, res_byte_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [23:0]           rsp_data_ff, rsp_data_in;
   logic [7:0]            bytes_in_use_ff, bytes_in_use_in;

   logic                  req_fire;
   logic [7:0]            limit;
   logic [6:0]            req_start;
   logic [9:0]            req_id;
   op_type                req_op;
   logic                  req_id_ok;
   logic [BYTE_POS_W-1:0] base_next;
   logic [WB_LOG2-1:0]    bit_idx;
   logic [WB_LOG2-1:0]    byte_sh;
   logic [WORD_BITS-1:0]  mod_word;
   logic                  out_free;
   hit_type               hit;

   assign req_op    = op_type'(req_tdata[1:0]);
   assign req_start = req_tdata[8:2];
   assign req_id    = req_tdata[18:9];
   assign req_id_ok = (req_id < ID_COUNT);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // search limit is clipped to the bitmap size
   assign limit = ({24'd0, bytes_in_use_ff} > TOTAL_BYTES) ? 8'(TOTAL_BYTES) : bytes_in_use_ff;

   assign base_next = base_ff + BYTE_POS_W'(BPW);
   assign bit_idx   = id_ff[WB_LOG2-1:0];
   assign byte_sh   = bit_idx & ~WB_LOG2'(7);
   assign mod_word  = (op_ff == OP_MARK) ? (rd_data_ff | (WORD_BITS'(1) << bit_idx))
                                         : (rd_data_ff & ~(WORD_BITS'(1) << bit_idx));

   ibma_word_scan #(
      .WORD_BITS (WORD_BITS)
   ) u_scan (
      .word       (rd_data_ff),
      .base       (base_ff),
      .start_byte (start_ff),
      .limit      (limit),
      .hit        (hit)
   );

   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      base_in         = base_ff;
      start_in        = start_ff;
      op_in           = op_ff;
      id_in           = id_ff;
      res_found_in    = res_found_ff;
      res_id_in       = res_id_ff;
      res_byte_in     = res_byte_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      bytes_in_use_in = csr_valid ? csr_data : bytes_in_use_ff;
      mem_re          = 1'b0;
      mem_we          = 1'b0;
      rd_addr         = '0;
      wr_addr         = '0;
      wr_data         = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we  = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(WORD_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               start_in     = req_start;
               op_in        = req_op;
               id_in        = req_id;
               res_found_in = 1'b0;
               res_id_in    = '0;
               res_byte_in  = '0;
               state_in     = ST_DONE;
               case (req_op)
                  OP_FIND: begin
                     // begin at the word holding start_byte
                     base_in = BYTE_POS_W'(req_start) & ~BYTE_POS_W'(BPW - 1);
                     if ({1'b0, req_start} < limit) begin
                        mem_re   = 1'b1;
                        rd_addr  = AW'(base_in >> BPW_LOG2);
                        state_in = ST_EVAL;
                     end
                  end
                  OP_MARK, OP_RELEASE: begin
                     if (req_id_ok) begin
                        mem_re   = 1'b1;
                        rd_addr  = AW'(req_id >> WB_LOG2);
                        state_in = ST_EVAL;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_EVAL: begin
            if (op_ff == OP_FIND) begin
               if (hit.found) begin
                  res_found_in = 1'b1;
                  res_id_in    = hit.free_id;
                  state_in     = ST_DONE;
               end else if (base_next >= {2'b00, limit}) begin
                  state_in = ST_DONE;
               end else begin
                  base_in = base_next;
                  mem_re  = 1'b1;
                  rd_addr = AW'(base_next >> BPW_LOG2);
               end
            end else begin
               // read-modify-write; the item owns the block until it ends
               mem_we      = 1'b1;
               wr_addr     = AW'(id_ff >> WB_LOG2);
               wr_data     = mod_word;
               res_byte_in = 8'(mod_word >> byte_sh);
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, res_byte_ff, res_id_ff, res_found_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         usage_mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= usage_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         bytes_in_use_ff <= 8'd128;
      end else begin
         state_ff        <= state_in;
         clr_ff          <= clr_in;
         rsp_valid_ff    <= rsp_valid_in;
         bytes_in_use_ff <= bytes_in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      start_ff     <= start_in;
      op_ff        <= op_in;
      id_ff        <= id_in;
      res_found_ff <= res_found_in;
      res_id_ff    <= res_id_in;
      res_byte_ff  <= res_byte_in;
      rsp_data_ff  <= rsp_data_in;
   end

   `IBMA_ASSERT_IMPL(a_no_beat_in_clear, state_ff == ST_CLEAR, !req_tready)
   `IBMA_ASSERT_NEXT(a_beat_leaves_idle, req_fire, state_ff != ST_IDLE)
   `IBMA_ASSERT_IMPL(a_write_state, mem_we, (state_ff == ST_CLEAR) || (state_ff == ST_EVAL))
   `IBMA_ASSERT_IMPL(a_found_no_byte, rsp_valid_ff && rsp_data_ff[0], rsp_data_ff[18:11] == 8'd0)

endmodule
